FILE: hw/rtl/cau_pkg.sv
// shared types, operation codes and saturation helpers for the complex arithmetic unit
// no dependencies; imported by every module of the block
package cau_pkg;

	localparam int CMD_W = 4;

	// command codes as they arrive on s_tuser
	localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_CMUL  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RECIP = 4'd5;
	localparam logic [CMD_W-1:0] CMD_CONJ  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_MAGSQ = 4'd7;
	localparam logic [CMD_W-1:0] CMD_COPY  = 4'd8;

	// internal operation classes handed from front to back
	localparam int CLS_W = 3;
	localparam logic [CLS_W-1:0] CLS_ADD  = 3'd0;
	localparam logic [CLS_W-1:0] CLS_SUB  = 3'd1;
	localparam logic [CLS_W-1:0] CLS_CONJ = 3'd2;
	localparam logic [CLS_W-1:0] CLS_COPY = 3'd3;
	localparam logic [CLS_W-1:0] CLS_PROD = 3'd4;
	localparam logic [CLS_W-1:0] CLS_DIV  = 3'd5;
	localparam logic [CLS_W-1:0] CLS_NONE = 3'd6;

	// quotient bits kept by the divider, enough to see any 32-bit saturation
	localparam int QB = 33;

	localparam logic [31:0] POS_MAX = 32'h7fffffff;
	localparam logic [31:0] NEG_MIN = 32'h80000000;

	// products formed by the back end: p0 = xr*yr, p1 = xi*yi, p2 = xr*yi, p3 = xi*yr
	// re = p0 +/- p1, im = +/-p2 +/- p3
	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic             neg1;
		logic             neg2;
		logic             neg3;
		logic             im_zero;
		logic signed [31:0] xr;
		logic signed [31:0] xi;
		logic signed [31:0] yr;
		logic signed [31:0] yi;
	} cau_op_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// saturate a 33-bit two's complement sum
	function automatic sat_t sat_sum(input logic [32:0] v);
		sat_t r;
		r.ovf = v[32] ^ v[31];
		r.val = r.ovf ? (v[32] ? NEG_MIN : POS_MAX) : v[31:0];
		return r;
	endfunction

	// clamp a sign-magnitude value to 32-bit two's complement
	function automatic sat_t sat_sm(input logic neg, input logic big, input logic [63:0] q);
		sat_t        r;
		logic [63:0] lim;
		logic [63:0] qq;
		lim   = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7fff_ffff;
		r.ovf = big || (q > lim);
		qq    = r.ovf ? lim : q;
		r.val = neg ? 32'(64'd0 - qq) : qq[31:0];
		return r;
	endfunction

endpackage

FILE: hw/rtl/cau_front.sv
// front end: takes input transactions and maps each command onto an operation class
// depends on cau_pkg; feeds cau_queue
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [127:0]       s_tdata,  // a_re, a_im, b_re, b_im
	input  logic [CMD_W-1:0]   s_tuser,  // command
	input  logic               q_full,
	output logic               push,
	output cau_op_t            op
);

	logic [CMD_W-1:0] cmd;
	logic [31:0]      ar, ai, br, bi;

	assign cmd = s_tuser;
	assign ar  = s_tdata[31:0];
	assign ai  = s_tdata[63:32];
	assign br  = s_tdata[95:64];
	assign bi  = s_tdata[127:96];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		op         = '0;
		op.cls     = CLS_NONE;
		op.xr      = ar;
		op.xi      = ai;
		op.yr      = br;
		op.yi      = bi;
		case (cmd)
			CMD_ADD:  op.cls = CLS_ADD;
			CMD_SUB:  op.cls = CLS_SUB;
			CMD_MUL: begin
				op.cls  = CLS_PROD;
				op.neg1 = 1'b1;
			end
			CMD_CMUL: begin
				op.cls  = CLS_PROD;
				op.neg3 = 1'b1;
			end
			CMD_DIV: begin
				op.cls  = CLS_DIV;
				op.neg2 = 1'b1;
			end
			CMD_RECIP: begin
				// one over a, as (1 + 0i) / a
				op.cls  = CLS_DIV;
				op.neg2 = 1'b1;
				op.xr   = 32'(64'd1 << FRAC_BITS);
				op.xi   = '0;
				op.yr   = ar;
				op.yi   = ai;
			end
			CMD_CONJ: op.cls = CLS_CONJ;
			CMD_MAGSQ: begin
				op.cls     = CLS_PROD;
				op.yr      = ar;
				op.yi      = ai;
				op.im_zero = 1'b1;
			end
			CMD_COPY: op.cls = CLS_COPY;
			default:  op.cls = CLS_NONE;
		endcase
	end

endmodule

FILE: hw/rtl/cau_queue.sv
// small register queue between front end and back end
// depends on cau_pkg only for house consistency of imports
module cau_queue import cau_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             avail
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign avail = cnt_q != '0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

FILE: hw/rtl/cau_back.sv
// back end: product stage, sums, rounding, pipelined restoring divider, output register
// depends on cau_pkg; pulls operations from cau_queue
module cau_back import cau_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_avail,
	input  cau_op_t       in_op,
	output logic          in_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // r_re, r_im
	output logic [1:0]    m_tuser   // overflow, div_by_zero
);

	localparam int DW = (FRAC_BITS > QB) ? 64 + FRAC_BITS : 64 + QB;
	localparam int PW = 64 - FRAC_BITS + 1;

	typedef struct packed {
		logic             is_div;
		logic             dz;
		logic             neg_re;
		logic             neg_im;
		logic             big_re;
		logic             big_im;
		logic [63:0]      d;
		logic [DW-1:0]    rem_re;
		logic [DW-1:0]    rem_im;
		logic [QB-1:0]    q_re;
		logic [QB-1:0]    q_im;
		sat_t             e_re;
		sat_t             e_im;
	} dstg_t;

	// one restoring step at quotient bit k on both components
	function automatic dstg_t div_step(input dstg_t s, input int k);
		dstg_t         r;
		logic [DW-1:0] sh;
		r  = s;
		sh = DW'(s.d) << k;
		if (s.rem_re >= sh) begin
			r.rem_re  = s.rem_re - sh;
			r.q_re[k] = 1'b1;
		end
		if (s.rem_im >= sh) begin
			r.rem_im  = s.rem_im - sh;
			r.q_im[k] = 1'b1;
		end
		return r;
	endfunction

	logic vld_q;
	logic adv;

	assign adv    = !vld_q || m_tready;
	assign in_pop = adv && in_avail;

	// stage 1: products and the simple operations
	logic               vld_s1;
	logic [CLS_W-1:0]   cls_s1;
	logic               neg1_s1, neg2_s1, neg3_s1, imz_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic [63:0]        d0_s1, d1_s1;
	sat_t               sre_s1, sim_s1;
	sat_t               sre, sim;

	always_comb begin
		sre = '0;
		sim = '0;
		case (in_op.cls)
			CLS_ADD: begin
				sre = sat_sum({in_op.xr[31], in_op.xr} + {in_op.yr[31], in_op.yr});
				sim = sat_sum({in_op.xi[31], in_op.xi} + {in_op.yi[31], in_op.yi});
			end
			CLS_SUB: begin
				sre = sat_sum({in_op.xr[31], in_op.xr} - {in_op.yr[31], in_op.yr});
				sim = sat_sum({in_op.xi[31], in_op.xi} - {in_op.yi[31], in_op.yi});
			end
			CLS_CONJ: begin
				sre.val = in_op.xr;
				sim     = sat_sum(33'd0 - {in_op.xi[31], in_op.xi});
			end
			CLS_COPY: begin
				sre.val = in_op.xr;
				sim.val = in_op.xi;
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
	end

	// stage 2: sums; stage 3: sign and magnitude; stage 4: product rounding, divider setup
	logic               vld_s2, vld_s3, vld_s4;
	logic [CLS_W-1:0]   cls_s2, cls_s3, cls_s4;
	logic               imz_s2, imz_s3, imz_s4;
	sat_t               sre_s2, sim_s2, sre_s3, sim_s3, sre_s4, sim_s4;
	logic signed [64:0] re_s2, im_s2;
	logic [63:0]        d_s2, d_s3, d_s4;
	logic               negre_s3, negim_s3, negre_s4, negim_s4;
	logic [63:0]        magre_s3, magim_s3;
	logic               dz_s3, dz_s4;
	logic [PW-1:0]      qre_s4, qim_s4;
	logic               bigre_s4, bigim_s4;
	logic [DW-1:0]      remre_s4, remim_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_avail;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1  <= in_op.cls;
			neg1_s1 <= in_op.neg1;
			neg2_s1 <= in_op.neg2;
			neg3_s1 <= in_op.neg3;
			imz_s1  <= in_op.im_zero;
			p0_s1   <= 64'(in_op.xr) * 64'(in_op.yr);
			p1_s1   <= 64'(in_op.xi) * 64'(in_op.yi);
			p2_s1   <= 64'(in_op.xr) * 64'(in_op.yi);
			p3_s1   <= 64'(in_op.xi) * 64'(in_op.yr);
			d0_s1   <= 64'(in_op.yr) * 64'(in_op.yr);
			d1_s1   <= 64'(in_op.yi) * 64'(in_op.yi);
			sre_s1  <= sre;
			sim_s1  <= sim;

			cls_s2  <= cls_s1;
			imz_s2  <= imz_s1;
			sre_s2  <= sre_s1;
			sim_s2  <= sim_s1;
			re_s2   <= 65'(p0_s1) + (neg1_s1 ? -65'(p1_s1) : 65'(p1_s1));
			im_s2   <= (neg2_s1 ? -65'(p2_s1) : 65'(p2_s1))
			         + (neg3_s1 ? -65'(p3_s1) : 65'(p3_s1));
			d_s2    <= d0_s1 + d1_s1;

			cls_s3   <= cls_s2;
			imz_s3   <= imz_s2;
			sre_s3   <= sre_s2;
			sim_s3   <= sim_s2;
			negre_s3 <= re_s2[64];
			negim_s3 <= im_s2[64];
			magre_s3 <= re_s2[64] ? 64'(-re_s2) : 64'(re_s2);
			magim_s3 <= im_s2[64] ? 64'(-im_s2) : 64'(im_s2);
			d_s3     <= d_s2;
			dz_s3    <= d_s2 == '0;

			cls_s4   <= cls_s3;
			imz_s4   <= imz_s3;
			sre_s4   <= sre_s3;
			sim_s4   <= sim_s3;
			negre_s4 <= negre_s3;
			negim_s4 <= negim_s3;
			d_s4     <= d_s3;
			dz_s4    <= dz_s3;
			// round to nearest, ties away from zero
			qre_s4   <= PW'(magre_s3 >> FRAC_BITS) + PW'(magre_s3[FRAC_BITS-1]);
			qim_s4   <= PW'(magim_s3 >> FRAC_BITS) + PW'(magim_s3[FRAC_BITS-1]);
			// quotient at or above 2^QB always saturates
			bigre_s4 <= (DW'(magre_s3) << FRAC_BITS) >= (DW'(d_s3) << QB);
			bigim_s4 <= (DW'(magim_s3) << FRAC_BITS) >= (DW'(d_s3) << QB);
			remre_s4 <= DW'(magre_s3) << FRAC_BITS;
			remim_s4 <= DW'(magim_s3) << FRAC_BITS;
		end
	end

	// divider entry, with the finished result of every other class
	dstg_t head;

	always_comb begin
		head        = '0;
		head.is_div = cls_s4 == CLS_DIV;
		head.dz     = dz_s4;
		head.neg_re = negre_s4;
		head.neg_im = negim_s4;
		head.big_re = bigre_s4;
		head.big_im = bigim_s4;
		head.d      = d_s4;
		head.rem_re = remre_s4;
		head.rem_im = remim_s4;
		case (cls_s4)
			CLS_PROD: begin
				head.e_re = sat_sm(negre_s4, 1'b0, 64'(qre_s4));
				head.e_im = imz_s4 ? '0 : sat_sm(negim_s4, 1'b0, 64'(qim_s4));
			end
			CLS_DIV: begin
				head.e_re = '0;
				head.e_im = '0;
			end
			default: begin
				head.e_re = sre_s4;
				head.e_im = sim_s4;
			end
		endcase
	end

	// divider stages, one quotient bit each, most significant first
	dstg_t         dstg_q [QB];
	dstg_t         dnxt   [QB];
	logic [QB-1:0] dvld_q;

	always_comb begin
		dnxt[0] = div_step(head, QB-1);
		for (int t = 1; t < QB; t++) begin
			dnxt[t] = div_step(dstg_q[t-1], QB-1-t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_q <= '0;
		end else if (adv) begin
			dvld_q <= {dvld_q[QB-2:0], vld_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int t = 0; t < QB; t++) begin
				dstg_q[t] <= dnxt[t];
			end
		end
	end

	// stage 5: divider rounding
	dstg_t        last;
	logic         rup_re, rup_im;
	logic         vld_s5;
	dstg_t        fin_s5;
	logic [QB:0]  qre_s5, qim_s5;

	assign last   = dstg_q[QB-1];
	assign rup_re = ({1'b0, last.rem_re} << 1) >= (DW+1)'(last.d);
	assign rup_im = ({1'b0, last.rem_im} << 1) >= (DW+1)'(last.d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= dvld_q[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s5 <= last;
			qre_s5 <= (QB+1)'(last.q_re) + (QB+1)'(rup_re);
			qim_s5 <= (QB+1)'(last.q_im) + (QB+1)'(rup_im);
		end
	end

	// final select and output register
	sat_t ore, oim;
	logic odz;

	always_comb begin
		odz = 1'b0;
		if (!fin_s5.is_div) begin
			ore = fin_s5.e_re;
			oim = fin_s5.e_im;
		end else if (fin_s5.dz) begin
			ore = '0;
			oim = '0;
			odz = 1'b1;
		end else begin
			ore = sat_sm(fin_s5.neg_re, fin_s5.big_re, 64'(qre_s5));
			oim = sat_sm(fin_s5.neg_im, fin_s5.big_im, 64'(qim_s5));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {oim.val, ore.val};
			m_tuser <= {odz, ore.ovf | oim.ovf};
		end
	end

	assign m_tvalid = vld_q;

endmodule

FILE: hw/rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit: front end, operation queue, back end
// depends on cau_pkg, cau_front, cau_queue, cau_back
//
// stateless complex alu on signed fixed point with FRAC_BITS fraction bits (q16.16 by
// default). each input transaction carries a command in s_tuser and operands a and b in
// s_tdata; each one yields exactly one output transaction with the result in m_tdata and
// the overflow and divide-by-zero flags in m_tuser. commands: add, subtract, multiply,
// conj(a)*b, a/b, 1/a, conj(a), |a|^2 (imaginary part zero) and copy; unused codes give
// all zeros. products and quotients round to nearest with ties away from zero, and any
// component outside 32 bits clamps to the bound and sets overflow. a zero divisor gives
// zero with div_by_zero set. the unit takes one transaction per clock unless the output
// stalls, and every command has the same latency from input acceptance to m_tvalid, through
// the queue, four stages of multiply, sum, magnitude and rounding, the 33-stage restoring
// divider (one quotient bit per stage), divider rounding and the output register. a two-entry
// queue sits between the command decoder and the datapath; the datapath stalls as a whole
// only while a finished result waits in the output register, so with m_tready held high nothing ever stalls.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int QDEPTH    = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [127:0]       s_tdata,  // a_re [31:0], a_im [63:32], b_re [95:64], b_im [127:96]
	input  logic [CMD_W-1:0]   s_tuser,  // command
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata,  // r_re [31:0], r_im [63:32]
	output logic [1:0]         m_tuser   // overflow [0], div_by_zero [1]
);

	cau_op_t fe_op;
	cau_op_t be_op;
	logic    fe_push;
	logic    q_full;
	logic    q_avail;
	logic    be_pop;

	// decode the command into an operation class and operand routing
	cau_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (fe_push),
		.op       (fe_op)
	);

	// decoupling queue, lets the decoder keep accepting while the datapath stalls, until the queue is full
	cau_queue #(
		.WIDTH ($bits(cau_op_t)),
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.din    (fe_op),
		.full   (q_full),
		.pop    (be_pop),
		.dout   (be_op),
		.avail  (q_avail)
	);

	// datapath with divider and output register
	cau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_avail (q_avail),
		.in_op    (be_op),
		.in_pop   (be_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hw/rtl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit
module cau_checker import cau_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [127:0]       s_tdata,  // a_re, a_im, b_re, b_im
	input logic [CMD_W-1:0]   s_tuser,  // command
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [63:0]        m_tdata,  // r_re, r_im
	input logic [1:0]         m_tuser   // overflow, div_by_zero
);

	logic [7:0] cnt_q;
	logic       s_xfer, m_xfer;

	assign s_xfer = s_tvalid && s_tready;
	assign m_xfer = m_tvalid && m_tready;

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_xfer && !m_xfer) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (m_xfer && !s_xfer) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cnt_q != '0))
		else $error("result shown with no transaction in flight");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && m_tdata == '0))
		else $error("divide by zero without a clean zero result");

	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
			(m_tdata[31:0] == POS_MAX || m_tdata[31:0] == NEG_MIN ||
			 m_tdata[63:32] == POS_MAX || m_tdata[63:32] == NEG_MIN))
		else $error("overflow flagged without a clamped component");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
